// File: hdl/cami_pkg.sv
`default_nettype none
package cami_pkg;

   // Field widths of the request and response transactions
   localparam int KIND_W     = 3;
   localparam int ENTRY_W    = 8;
   localparam int DATA_W     = 16;
   localparam int IDX_OUT_W  = 4;
   localparam int FRAC_OUT_W = 16;
   localparam int CSR_W      = 5;

   // Value table
   localparam int VALUE_AW = 8;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_WRITE_X = 3'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE_Y = 3'd1;
   localparam logic [KIND_W-1:0] KIND_WRITE_V = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CURVE   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_MAP     = 3'd4;

   // Register indexes
   localparam logic CSR_X_POINTS = 1'b0;
   localparam logic CSR_Y_POINTS = 1'b1;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_SCAN,
      ST_DIV,
      ST_BASE,
      ST_RA,
      ST_RB,
      ST_RC,
      ST_LW,
      ST_LF,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

// File: hdl/cami_if.sv
`default_nettype none
interface cami_req_if;
   logic                                  valid;
   logic                                  ready;
   logic        [cami_pkg::KIND_W-1:0]    kind;
   logic        [cami_pkg::ENTRY_W-1:0]   entry_index;
   logic signed [cami_pkg::DATA_W-1:0]    write_value;
   logic signed [cami_pkg::DATA_W-1:0]    x_in;
   logic signed [cami_pkg::DATA_W-1:0]    y_in;

   modport source (output valid, kind, entry_index, write_value, x_in, y_in, input ready);
   modport sink   (input valid, kind, entry_index, write_value, x_in, y_in, output ready);
endinterface

interface cami_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [cami_pkg::DATA_W-1:0]     result;
   logic        [cami_pkg::IDX_OUT_W-1:0]  x_index;
   logic        [cami_pkg::FRAC_OUT_W-1:0] x_fraction;
   logic        [cami_pkg::IDX_OUT_W-1:0]  y_index;
   logic        [cami_pkg::FRAC_OUT_W-1:0] y_fraction;
   logic                                  zero_width_error;

   modport source (output valid, result, x_index, x_fraction, y_index, y_fraction,
                   zero_width_error, input ready);
   modport sink   (input valid, result, x_index, x_fraction, y_index, y_fraction,
                   zero_width_error, output ready);
endinterface
`default_nettype wire

// File: hdl/cami_divider.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle; dividend is below divisor
module cami_divider #(
   parameter int FW = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [16:0]   dividend,
   input  wire logic [16:0]   divisor,
   output logic               done,
   output logic [FW-1:0]      quotient
);

   localparam int CW = $clog2(FW + 1);

   logic [17:0]   rem_ff, rem_in;
   logic [16:0]   div_ff;
   logic [FW-1:0] quo_ff, quo_in;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [17:0]   shifted;
   logic          take;

   // One trial subtraction
   always_comb begin
      shifted = {rem_ff[16:0], 1'b0};
      take    = shifted >= {1'b0, div_ff};
      rem_in  = take ? (shifted - {1'b0, div_ff}) : shifted;
      quo_in  = {quo_ff[FW-2:0], take};
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(FW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {1'b0, dividend};
         div_ff <= divisor;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

`ifndef SYNTHESIS
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("divider restarted while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without work");
   a_idle_after_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider still busy at done");
`endif

endmodule
`default_nettype wire

// File: hdl/cami_lerp.sv
`default_nettype none
// Linear step a + floor((b - a) * frac / 2^FW), registered product then registered result
module cami_lerp #(
   parameter int FW = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [15:0] a,
   input  wire logic signed [15:0] b,
   input  wire logic [FW-1:0]      frac,
   output logic                    done,
   output logic signed [15:0]      res
);

   localparam int PW = 17 + FW + 1;

   logic signed [16:0]   diff;
   logic signed [FW:0]   frac_s;
   logic signed [PW-1:0] prod_in, prod_ff;
   logic signed [PW-1:0] step;
   logic signed [15:0]   a_ff;
   logic signed [15:0]   res_ff, res_in;
   logic                 s1_ff, done_ff;

   // Zero fraction forces a zero step
   always_comb begin
      diff    = (frac == '0) ? 17'sd0 : ({b[15], b} - {a[15], a});
      frac_s  = {1'b0, frac};
      prod_in = diff * frac_s;
      step    = prod_ff >>> FW;
      res_in  = a_ff + step[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         s1_ff   <= start;
         done_ff <= s1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= prod_in;
         a_ff    <= a;
      end
      if (s1_ff) begin
         res_ff <= res_in;
      end
   end

   assign done = done_ff;
   assign res  = res_ff;

`ifndef SYNTHESIS
   a_done_follows: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(start, 2)) else $error("lerp done without start");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      s1_ff |-> !start) else $error("lerp started back to back");
   a_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("lerp done longer than a cycle");
`endif

endmodule
`default_nettype wire

// File: hdl/curve_and_map_table_interpolator.sv
`default_nettype none
// Channel   Dir   Contents
// req_if    in    kind, entry_index, write_value, x_in, y_in
// rsp_if    out   result, x_index, x_fraction, y_index, y_fraction, zero_width_error
// csr_*     in    write enable, register index, data (x_points, y_points)
//
// Writes are stored when the request is accepted. Per axis searched, a lookup reads the
// end breakpoints, scans once per breakpoint passed plus once more, and runs the serial
// divider when the input lies strictly inside an interval. Then it forms the base address,
// makes one row step per row (curve: 1 row, map: 2), makes the map's final X step and
// loads the output register, waiting while a result there is still not taken. The single
// axis read port and the shared divider and multiplier let one lookup run at a time.
// Reset is synchronous; table contents are not cleared. A new request is taken while
// a finished result still waits in the output register.
module curve_and_map_table_interpolator #(
   parameter int MAX_X_POINTS  = 16,
   parameter int MAX_Y_POINTS  = 16,
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   cami_req_if.sink                          req_if,
   cami_rsp_if.source                        rsp_if,
   input  wire logic                         csr_we,
   input  wire logic                         csr_index,
   input  wire logic [cami_pkg::CSR_W-1:0]   csr_wdata
);

   localparam int XAW = $clog2(MAX_X_POINTS);
   localparam int YAW = $clog2(MAX_Y_POINTS);
   localparam int AW  = (XAW > YAW) ? XAW : YAW;
   localparam int NW  = AW + 1;
   localparam int FW  = FRACTION_BITS;
   localparam int VD  = 1 << cami_pkg::VALUE_AW;

   cami_pkg::state_type state_ff, state_in;

   logic [cami_pkg::CSR_W-1:0] x_points_ff, y_points_ff;
   logic [NW-1:0]              nx, ny, n;

   // Stores
   logic signed [15:0] x_mem [MAX_X_POINTS];
   logic signed [15:0] y_mem [MAX_Y_POINTS];
   logic signed [15:0] v_mem [VD];
   logic signed [15:0] x_rd_ff, y_rd_ff, v_rd_ff;
   logic [AW-1:0]      ax_addr;
   logic [7:0]         v_addr;

   // Transaction and search registers
   logic               acc;
   logic               map_ff, map_in;
   logic signed [15:0] xin_ff, xin_in, yin_ff, yin_in;
   logic               sel_y_ff, sel_y_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic signed [15:0] lo_ff, lo_in, first_ff, first_in;
   logic               rising_ff, rising_in;
   logic [AW-1:0]      xidx_ff, xidx_in, yidx_ff, yidx_in;
   logic [FW-1:0]      xfrac_ff, xfrac_in, yfrac_ff, yfrac_in;
   logic               err_ff, err_in;
   logic               pair_ff, pair_in;
   logic [7:0]         base_ff, base_in, pair_addr;
   logic signed [15:0] v0_ff, v0_in, lores_ff, lores_in, res_ff, res_in;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_map_ff;
   logic signed [15:0] rsp_res_ff;
   logic [AW-1:0]      rsp_xidx_ff, rsp_yidx_ff;
   logic [FW-1:0]      rsp_xfrac_ff, rsp_yfrac_ff;
   logic               rsp_err_ff;
   logic               load_rsp;

   // Search datapath
   logic signed [15:0] rd, v;
   logic signed [16:0] num, den;
   logic [16:0]        un, ud;
   logic               reach, more, rising_now;
   logic               fin, fin_zw;
   logic [AW-1:0]      fin_idx;
   logic [FW-1:0]      fin_frac;

   // Shared units
   logic               div_start, div_done;
   logic [FW-1:0]      div_q;
   logic               lerp_start, lerp_done;
   logic signed [15:0] lerp_a, lerp_b, lerp_res;
   logic [FW-1:0]      lerp_frac;

   assign acc = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == cami_pkg::ST_IDLE);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_points_ff <= cami_pkg::CSR_W'(16);
         y_points_ff <= cami_pkg::CSR_W'(16);
      end else if (csr_we) begin
         case (csr_index)
            cami_pkg::CSR_X_POINTS: x_points_ff <= csr_wdata;
            cami_pkg::CSR_Y_POINTS: y_points_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Effective point counts
   always_comb begin
      if (x_points_ff == '0) nx = NW'(1);
      else if (int'(x_points_ff) > MAX_X_POINTS) nx = NW'(MAX_X_POINTS);
      else nx = NW'(x_points_ff);
      if (y_points_ff == '0) ny = NW'(1);
      else if (int'(y_points_ff) > MAX_Y_POINTS) ny = NW'(MAX_Y_POINTS);
      else ny = NW'(y_points_ff);
   end

   // Store writes and registered reads
   always_ff @(posedge clock) begin
      if (acc && req_if.kind == cami_pkg::KIND_WRITE_X
          && int'(req_if.entry_index) < MAX_X_POINTS) begin
         x_mem[req_if.entry_index[XAW-1:0]] <= req_if.write_value;
      end
      if (acc && req_if.kind == cami_pkg::KIND_WRITE_Y
          && int'(req_if.entry_index) < MAX_Y_POINTS) begin
         y_mem[req_if.entry_index[YAW-1:0]] <= req_if.write_value;
      end
      if (acc && req_if.kind == cami_pkg::KIND_WRITE_V) begin
         v_mem[req_if.entry_index] <= req_if.write_value;
      end
      x_rd_ff <= x_mem[ax_addr[XAW-1:0]];
      y_rd_ff <= y_mem[ax_addr[YAW-1:0]];
      v_rd_ff <= v_mem[v_addr];
   end

   // Search compare and difference terms
   always_comb begin
      rd         = sel_y_ff ? y_rd_ff : x_rd_ff;
      v          = sel_y_ff ? yin_ff : xin_ff;
      n          = sel_y_ff ? ny : nx;
      num        = {v[15], v} - {lo_ff[15], lo_ff};
      den        = {rd[15], rd} - {lo_ff[15], lo_ff};
      un         = num[16] ? 17'(-num) : 17'(num);
      ud         = den[16] ? 17'(-den) : 17'(den);
      reach      = rising_ff ? (v >= rd) : (v <= rd);
      more       = ({1'b0, idx_ff} + NW'(1)) < (n - NW'(1));
      rising_now = first_ff <= rd;
      pair_addr  = base_ff + (pair_ff ? 8'(ny) : 8'd0);
   end

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      map_in     = map_ff;
      xin_in     = xin_ff;
      yin_in     = yin_ff;
      sel_y_in   = sel_y_ff;
      idx_in     = idx_ff;
      lo_in      = lo_ff;
      first_in   = first_ff;
      rising_in  = rising_ff;
      xidx_in    = xidx_ff;
      yidx_in    = yidx_ff;
      xfrac_in   = xfrac_ff;
      yfrac_in   = yfrac_ff;
      err_in     = err_ff;
      pair_in    = pair_ff;
      base_in    = base_ff;
      v0_in      = v0_ff;
      lores_in   = lores_ff;
      res_in     = res_ff;
      ax_addr    = '0;
      v_addr     = pair_addr;
      fin        = 1'b0;
      fin_zw     = 1'b0;
      fin_idx    = '0;
      fin_frac   = '0;
      div_start  = 1'b0;
      lerp_start = 1'b0;
      lerp_a     = v0_ff;
      lerp_b     = v_rd_ff;
      lerp_frac  = map_ff ? yfrac_ff : xfrac_ff;
      load_rsp   = 1'b0;

      case (state_ff)
         cami_pkg::ST_IDLE: begin
            if (acc && (req_if.kind == cami_pkg::KIND_CURVE
                        || req_if.kind == cami_pkg::KIND_MAP)) begin
               map_in   = req_if.kind == cami_pkg::KIND_MAP;
               xin_in   = req_if.x_in;
               yin_in   = req_if.y_in;
               sel_y_in = 1'b0;
               err_in   = 1'b0;
               yidx_in  = '0;
               yfrac_in = '0;
               state_in = cami_pkg::ST_FIRST;
            end
         end
         cami_pkg::ST_FIRST: begin
            first_in = rd;
            ax_addr  = AW'(n - NW'(1));
            state_in = cami_pkg::ST_LAST;
         end
         cami_pkg::ST_LAST: begin
            // Clamp below the first or beyond the last breakpoint
            if (rising_now ? (v <= first_ff) : (v >= first_ff)) begin
               fin = 1'b1;
            end else if (rising_now ? (v >= rd) : (v <= rd)) begin
               fin     = 1'b1;
               fin_idx = AW'(n - NW'(1));
            end else begin
               rising_in = rising_now;
               idx_in    = '0;
               lo_in     = first_ff;
               ax_addr   = AW'(1);
               state_in  = cami_pkg::ST_SCAN;
            end
         end
         cami_pkg::ST_SCAN: begin
            if (more && reach) begin
               idx_in  = idx_ff + AW'(1);
               lo_in   = rd;
               ax_addr = idx_ff + AW'(2);
            end else if (num == '0) begin
               fin     = 1'b1;
               fin_idx = idx_ff;
            end else if (den == '0) begin
               fin     = 1'b1;
               fin_idx = idx_ff;
               fin_zw  = 1'b1;
            end else if (num[16] != den[16]) begin
               fin     = 1'b1;
               fin_idx = idx_ff;
            end else if (un >= ud) begin
               fin      = 1'b1;
               fin_idx  = idx_ff;
               fin_frac = '1;
            end else begin
               div_start = 1'b1;
               state_in  = cami_pkg::ST_DIV;
            end
         end
         cami_pkg::ST_DIV: begin
            if (div_done) begin
               fin      = 1'b1;
               fin_idx  = idx_ff;
               fin_frac = div_q;
            end
         end
         cami_pkg::ST_BASE: begin
            base_in  = map_ff ? 8'(int'(xidx_ff) * int'(ny) + int'(yidx_ff)) : 8'(xidx_ff);
            pair_in  = 1'b0;
            state_in = cami_pkg::ST_RA;
         end
         cami_pkg::ST_RA: begin
            state_in = cami_pkg::ST_RB;
         end
         cami_pkg::ST_RB: begin
            v0_in    = v_rd_ff;
            v_addr   = pair_addr + 8'd1;
            state_in = cami_pkg::ST_RC;
         end
         cami_pkg::ST_RC: begin
            lerp_start = 1'b1;
            state_in   = cami_pkg::ST_LW;
         end
         cami_pkg::ST_LW: begin
            if (lerp_done) begin
               if (!map_ff) begin
                  res_in   = lerp_res;
                  state_in = cami_pkg::ST_OUT;
               end else if (!pair_ff) begin
                  lores_in = lerp_res;
                  pair_in  = 1'b1;
                  state_in = cami_pkg::ST_RA;
               end else begin
                  lerp_start = 1'b1;
                  lerp_a     = lores_ff;
                  lerp_b     = lerp_res;
                  lerp_frac  = xfrac_ff;
                  state_in   = cami_pkg::ST_LF;
               end
            end
         end
         cami_pkg::ST_LF: begin
            if (lerp_done) begin
               res_in   = lerp_res;
               state_in = cami_pkg::ST_OUT;
            end
         end
         cami_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               load_rsp = 1'b1;
               state_in = cami_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cami_pkg::ST_IDLE;
         end
      endcase

      // Axis search finished: record it, go on to Y or to the value reads
      if (fin) begin
         err_in = err_ff | fin_zw;
         if (!sel_y_ff) begin
            xidx_in  = fin_idx;
            xfrac_in = fin_frac;
            if (map_ff) begin
               sel_y_in = 1'b1;
               ax_addr  = '0;
               state_in = cami_pkg::ST_FIRST;
            end else begin
               state_in = cami_pkg::ST_BASE;
            end
         end else begin
            yidx_in  = fin_idx;
            yfrac_in = fin_frac;
            state_in = cami_pkg::ST_BASE;
         end
      end

      rsp_valid_in = (rsp_valid_ff && !rsp_if.ready) || load_rsp;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cami_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      map_ff    <= map_in;
      xin_ff    <= xin_in;
      yin_ff    <= yin_in;
      sel_y_ff  <= sel_y_in;
      idx_ff    <= idx_in;
      lo_ff     <= lo_in;
      first_ff  <= first_in;
      rising_ff <= rising_in;
      xidx_ff   <= xidx_in;
      yidx_ff   <= yidx_in;
      xfrac_ff  <= xfrac_in;
      yfrac_ff  <= yfrac_in;
      err_ff    <= err_in;
      pair_ff   <= pair_in;
      base_ff   <= base_in;
      v0_ff     <= v0_in;
      lores_ff  <= lores_in;
      res_ff    <= res_in;
      if (load_rsp) begin
         rsp_map_ff   <= map_ff;
         rsp_res_ff   <= res_ff;
         rsp_xidx_ff  <= xidx_ff;
         rsp_yidx_ff  <= yidx_ff;
         rsp_xfrac_ff <= xfrac_ff;
         rsp_yfrac_ff <= yfrac_ff;
         rsp_err_ff   <= err_ff;
      end
   end

   cami_divider #(.FW(FW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (un),
      .divisor  (ud),
      .done     (div_done),
      .quotient (div_q)
   );

   cami_lerp #(.FW(FW)) u_lerp (
      .clock (clock),
      .reset (reset),
      .start (lerp_start),
      .a     (lerp_a),
      .b     (lerp_b),
      .frac  (lerp_frac),
      .done  (lerp_done),
      .res   (lerp_res)
   );

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.result           = rsp_res_ff;
   assign rsp_if.x_index          = cami_pkg::IDX_OUT_W'(rsp_xidx_ff);
   assign rsp_if.x_fraction       = cami_pkg::FRAC_OUT_W'(rsp_xfrac_ff);
   assign rsp_if.y_index          = cami_pkg::IDX_OUT_W'(rsp_yidx_ff);
   assign rsp_if.y_fraction       = cami_pkg::FRAC_OUT_W'(rsp_yfrac_ff);
   assign rsp_if.zero_width_error = rsp_err_ff;

`ifndef SYNTHESIS
   a_div_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == cami_pkg::ST_DIV) else $error("divider done outside DIV");
   a_lerp_wait: assert property (@(posedge clock) disable iff (reset)
      lerp_done |-> (state_ff == cami_pkg::ST_LW || state_ff == cami_pkg::ST_LF))
      else $error("lerp done outside wait state");
   a_curve_no_y: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_map_ff |-> rsp_yidx_ff == '0 && rsp_yfrac_ff == '0)
      else $error("curve response carries Y terms");
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == cami_pkg::ST_OUT))
      else $error("response without OUT state");
`endif

endmodule
`default_nettype wire
